>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the sequencer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/lssq_pkg.sv
// Package for the load/store machine-cycle sequencer.
// Holds codes, the item/result/state types and the reset state. No dependencies.
package lssq_pkg;

    // Instruction kinds
    localparam logic [3:0] KIND_ST_NN_RR   = 4'd0;
    localparam logic [3:0] KIND_LD_RR_NN   = 4'd1;
    localparam logic [3:0] KIND_ST_NN_A    = 4'd2;
    localparam logic [3:0] KIND_LD_A_NN    = 4'd3;
    localparam logic [3:0] KIND_LD_R_HL    = 4'd4;
    localparam logic [3:0] KIND_ST_HL_R    = 4'd5;
    localparam logic [3:0] KIND_LD_RR_IMM  = 4'd6;
    localparam logic [3:0] KIND_LD_R_IMM   = 4'd7;
    localparam logic [3:0] KIND_ST_RR_A    = 4'd8;
    localparam logic [3:0] KIND_PUSH       = 4'd9;
    localparam logic [3:0] KIND_POP        = 4'd10;

    // Register pair selects
    localparam logic [2:0] PAIR_BC = 3'd0;
    localparam logic [2:0] PAIR_DE = 3'd1;
    localparam logic [2:0] PAIR_HL = 3'd2;
    localparam logic [2:0] PAIR_SP = 3'd3;
    localparam logic [2:0] PAIR_AF = 3'd4;
    localparam logic [2:0] PAIR_IX = 3'd5;
    localparam logic [2:0] PAIR_IY = 3'd6;

    // 8-bit register selects
    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_E = 3'd4;
    localparam logic [2:0] REG_H = 3'd5;
    localparam logic [2:0] REG_L = 3'd6;

    // Bus cycle kinds
    typedef enum logic [1:0] {
        BUS_READ     = 2'd0,
        BUS_WRITE    = 2'd1,
        BUS_INTERNAL = 2'd2,
        BUS_NONE     = 2'd3
    } bus_kind_t;

    // One input beat
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] reg_sel;
        logic [2:0] pair_sel;
        logic [3:0] kind;
    } item_t;

    // One result beat
    typedef struct packed {
        logic       done_res;
        logic [7:0] write_data;
        logic [15:0] bus_address;
        bus_kind_t  bus_kind;
    } result_t;

    // Architectural state of the sequencer
    typedef struct packed {
        logic [2:0]  step;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] af;
        logic [15:0] ix;
        logic [15:0] iy;
        logic [7:0]  tmp;
        logic [15:0] addr;
        bus_kind_t   ck;
    } state_t;

    localparam state_t STATE_RESET = '{
        step: 3'd1,
        pc:   16'h0000,
        sp:   16'hFFFF,
        bc:   16'hFFFF,
        de:   16'hFFFF,
        hl:   16'hFFFF,
        af:   16'hFFFF,
        ix:   16'hFFFF,
        iy:   16'hFFFF,
        tmp:  8'h00,
        addr: 16'h0000,
        ck:   BUS_READ
    };

endpackage

>>> rtl/core/load_store_machine_cycle_sequencer.sv
// Load/store machine-cycle sequencer for Z80-style loads, stores, push and pop.
// Usage:
//   Input stream (s_axis): one beat per machine cycle, carrying the instruction
//   kind, pair select, register select and the byte of the previous read.
//   Output stream (m_axis): one beat per input beat with the next bus cycle
//   kind (tuser), its address and write data (tdata); tlast marks the step
//   that completes the instruction.
//   Path: a beat enters the input register, the step logic works on it and the
//   result lands in the output register, from which it is offered.
//   Throughput: one beat per cycle while m_axis_tready does not stall; the step
//   count and registers update in the same cycle the result is registered, so
//   the next beat sees them at once.
//   Stall: while m_axis_tready is low the result holds; one more beat can sit in
//   the input register, after which s_axis_tready drops.
//   Reset: rst_n clears both stages, sets the step count to one, PC and the
//   address to zero, SP and all pairs to all ones.
// Depends on lssq_pkg, lssq_step and lssq_state.
module load_store_machine_cycle_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // kind[3:0], pair_sel[6:4], reg_sel[9:7],
                                        // read_data[17:10], zero pad[23:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bus_address[15:0], write_data[23:16]
    output logic [1:0]  m_axis_tuser,   // bus_kind[1:0]
    output logic        m_axis_tlast    // done_res
);
    import lssq_pkg::*;

    item_t   in_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    take_in;
    state_t  cur_state;
    state_t  nxt_state;
    result_t step_res;

    // Handshake between the two stages
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_reg.kind      <= s_axis_tdata[3:0];
            in_reg.pair_sel  <= s_axis_tdata[6:4];
            in_reg.reg_sel   <= s_axis_tdata[9:7];
            in_reg.read_data <= s_axis_tdata[17:10];
        end
        if (advance)
            out_reg <= step_res;
    end

    lssq_step u_step (
        .cur  (cur_state),
        .item (in_reg),
        .nxt  (nxt_state),
        .res  (step_res)
    );

    lssq_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .nxt    (nxt_state),
        .cur    (cur_state)
    );

    // Output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.write_data, out_reg.bus_address};
    assign m_axis_tuser  = out_reg.bus_kind;
    assign m_axis_tlast  = out_reg.done_res;

endmodule

>>> rtl/core/lssq_step.sv
// Combinational step logic: one machine cycle of a load/store/push/pop.
// Depends on lssq_pkg for the item, result and state types.
module lssq_step (
    input  lssq_pkg::state_t  cur,
    input  lssq_pkg::item_t   item,
    output lssq_pkg::state_t  nxt,
    output lssq_pkg::result_t res
);
    import lssq_pkg::*;

    // Read a register pair; unused select reads as zero
    function automatic logic [15:0] get_pair(state_t st, logic [2:0] sel);
        unique case (sel)
            PAIR_BC: return st.bc;
            PAIR_DE: return st.de;
            PAIR_HL: return st.hl;
            PAIR_SP: return st.sp;
            PAIR_AF: return st.af;
            PAIR_IX: return st.ix;
            PAIR_IY: return st.iy;
            default: return 16'h0000;
        endcase
    endfunction

    // Replace one byte of a pair; unused select is ignored
    function automatic state_t set_pair_byte(state_t st, logic [2:0] sel, logic high,
                                             logic [7:0] v);
        state_t      r;
        logic [15:0] val;
        r   = st;
        val = get_pair(st, sel);
        val = high ? {v, val[7:0]} : {val[15:8], v};
        unique case (sel)
            PAIR_BC: r.bc = val;
            PAIR_DE: r.de = val;
            PAIR_HL: r.hl = val;
            PAIR_SP: r.sp = val;
            PAIR_AF: r.af = val;
            PAIR_IX: r.ix = val;
            PAIR_IY: r.iy = val;
            default: ;
        endcase
        return r;
    endfunction

    // Read an 8-bit register; unused select reads as zero
    function automatic logic [7:0] get_r8(state_t st, logic [2:0] sel);
        unique case (sel)
            REG_A:   return st.af[15:8];
            REG_B:   return st.bc[15:8];
            REG_C:   return st.bc[7:0];
            REG_D:   return st.de[15:8];
            REG_E:   return st.de[7:0];
            REG_H:   return st.hl[15:8];
            REG_L:   return st.hl[7:0];
            default: return 8'h00;
        endcase
    endfunction

    // Write an 8-bit register; unused select is ignored
    function automatic state_t set_r8(state_t st, logic [2:0] sel, logic [7:0] v);
        state_t r;
        r = st;
        unique case (sel)
            REG_A:   r.af[15:8] = v;
            REG_B:   r.bc[15:8] = v;
            REG_C:   r.bc[7:0]  = v;
            REG_D:   r.de[15:8] = v;
            REG_E:   r.de[7:0]  = v;
            REG_H:   r.hl[15:8] = v;
            REG_L:   r.hl[7:0]  = v;
            default: ;
        endcase
        return r;
    endfunction

    // Operand fetch from the program counter
    function automatic state_t fetch_pc(state_t st);
        state_t r;
        r      = st;
        r.addr = st.pc;
        r.pc   = st.pc + 16'd1;
        return r;
    endfunction

    state_t      st;
    logic [2:0]  s;
    logic [7:0]  wd;
    logic [15:0] pv;
    logic        done;

    // Per-kind step sequencing
    always_comb
    begin
        st   = cur;
        s    = cur.step;
        wd   = 8'h00;
        pv   = 16'h0000;
        done = 1'b0;
        case (item.kind) inside
            KIND_ST_NN_RR, KIND_LD_RR_NN, KIND_ST_NN_A, KIND_LD_A_NN:
            begin
                if (s == 3'd1)
                begin
                    st.ck = BUS_READ;
                    st    = fetch_pc(st);
                end
                else if (s == 3'd2)
                begin
                    st.tmp = item.read_data;
                    st     = fetch_pc(st);
                end
                else if (s == 3'd3)
                begin
                    st.addr = {item.read_data, st.tmp};
                    if (item.kind == KIND_ST_NN_RR)
                    begin
                        st.ck = BUS_WRITE;
                        pv    = get_pair(st, item.pair_sel);
                        wd    = pv[7:0];
                    end
                    else if (item.kind == KIND_ST_NN_A)
                    begin
                        st.ck = BUS_WRITE;
                        wd    = get_r8(st, REG_A);
                    end
                end
                else if (s == 3'd4)
                begin
                    if (item.kind == KIND_ST_NN_RR)
                    begin
                        st.addr = st.addr + 16'd1;
                        pv      = get_pair(st, item.pair_sel);
                        wd      = pv[15:8];
                    end
                    else if (item.kind == KIND_LD_RR_NN)
                    begin
                        st      = set_pair_byte(st, item.pair_sel, 1'b0, item.read_data);
                        st.addr = st.addr + 16'd1;
                    end
                    else if (item.kind == KIND_ST_NN_A)
                        done = 1'b1;
                    else
                    begin
                        st   = set_r8(st, REG_A, item.read_data);
                        done = 1'b1;
                    end
                end
                else if (s == 3'd5 && item.kind == KIND_LD_RR_NN)
                begin
                    st   = set_pair_byte(st, item.pair_sel, 1'b1, item.read_data);
                    done = 1'b1;
                end
                else
                    done = 1'b1;
            end
            KIND_LD_R_HL:
            begin
                if (s == 3'd1)
                begin
                    st.ck   = BUS_READ;
                    st.addr = get_pair(st, PAIR_HL);
                end
                else
                begin
                    if (s == 3'd2)
                        st = set_r8(st, item.reg_sel, item.read_data);
                    done = 1'b1;
                end
            end
            KIND_ST_HL_R:
            begin
                if (s == 3'd1)
                begin
                    st.ck   = BUS_WRITE;
                    st.addr = get_pair(st, PAIR_HL);
                    wd      = get_r8(st, item.reg_sel);
                end
                else
                    done = 1'b1;
            end
            KIND_LD_RR_IMM:
            begin
                if (s == 3'd1)
                begin
                    st.ck = BUS_READ;
                    st    = fetch_pc(st);
                end
                else if (s == 3'd2)
                begin
                    st = set_pair_byte(st, item.pair_sel, 1'b0, item.read_data);
                    st = fetch_pc(st);
                end
                else
                begin
                    if (s == 3'd3)
                        st = set_pair_byte(st, item.pair_sel, 1'b1, item.read_data);
                    done = 1'b1;
                end
            end
            KIND_LD_R_IMM:
            begin
                if (s == 3'd1)
                begin
                    st.ck = BUS_READ;
                    st    = fetch_pc(st);
                end
                else
                begin
                    if (s == 3'd2)
                        st = set_r8(st, item.reg_sel, item.read_data);
                    done = 1'b1;
                end
            end
            KIND_ST_RR_A:
            begin
                if (s == 3'd1)
                begin
                    st.ck   = BUS_WRITE;
                    st.addr = get_pair(st, item.pair_sel);
                    wd      = get_r8(st, REG_A);
                end
                else
                    done = 1'b1;
            end
            KIND_PUSH:
            begin
                if (s == 3'd1)
                    st.ck = BUS_INTERNAL;
                else if (s == 3'd2 || s == 3'd3)
                begin
                    // SP is decremented first, so pushing SP sees the new value
                    st.ck   = BUS_WRITE;
                    st.sp   = st.sp - 16'd1;
                    st.addr = st.sp;
                    pv      = get_pair(st, item.pair_sel);
                    wd      = (s == 3'd2) ? pv[15:8] : pv[7:0];
                end
                else
                    done = 1'b1;
            end
            KIND_POP:
            begin
                if (s == 3'd1)
                begin
                    st.ck   = BUS_READ;
                    st.addr = st.sp;
                end
                else if (s == 3'd2)
                begin
                    st      = set_pair_byte(st, item.pair_sel, 1'b0, item.read_data);
                    st.addr = st.addr + 16'd1;
                end
                else
                begin
                    // final SP update wins over a pop into SP
                    if (s == 3'd3)
                    begin
                        st      = set_pair_byte(st, item.pair_sel, 1'b1, item.read_data);
                        st.addr = st.addr + 16'd1;
                        st.sp   = st.addr;
                    end
                    done = 1'b1;
                end
            end
            default:
                done = 1'b1;
        endcase

        st.step = done ? 3'd1 : s + 3'd1;
    end

    // Result beat and next state
    always_comb
    begin
        nxt             = st;
        res.bus_kind    = done ? BUS_NONE : st.ck;
        res.bus_address = st.addr;
        res.write_data  = (!done && st.ck == BUS_WRITE) ? wd : 8'h00;
        res.done_res    = done;
    end

endmodule

>>> rtl/core/lssq_state.sv
// Architectural state registers of the sequencer (PC, SP, pairs, address, step).
// Depends on lssq_pkg for state_t and the reset state.
module lssq_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  lssq_pkg::state_t  nxt,
    output lssq_pkg::state_t  cur
);
    import lssq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold unless a step commits
    always_comb
    begin
        state_next = commit ? nxt : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

    assign cur = state_reg;

endmodule

>>> rtl/core/lssq_checker.sv
// Port-level checker for the sequencer, bound to the top level below.
// Depends on lssq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lssq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import lssq_pkg::*;

    // A completing step reports no bus cycle
    `ASSERT_IMPLIES(a_done_no_bus, m_axis_tvalid && m_axis_tlast, m_axis_tuser == BUS_NONE)

    // Only a completing step reports no-bus as its kind
    `ASSERT_IMPLIES(a_none_is_done, m_axis_tvalid && m_axis_tuser == BUS_NONE, m_axis_tlast)

    // Write data is driven only on write cycles
    `ASSERT_IMPLIES(a_wdata_zero, m_axis_tvalid && m_axis_tuser != BUS_WRITE,
                    m_axis_tdata[23:16] == 8'h00)

    // A stalled result beat holds
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // With no result waiting the input side always takes a beat
    `ASSERT_IMPLIES(a_ready_when_out_free, !m_axis_tvalid && s_axis_tvalid, s_axis_tready)

endmodule

bind load_store_machine_cycle_sequencer lssq_checker u_lssq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/load_store_machine_cycle_sequencer_tb.sv
// Self-checking testbench for load_store_machine_cycle_sequencer: a directed table
// followed by random instruction sequences, checked against an in-bench model.
// Depends on lssq_pkg and the sequencer RTL only.
`timescale 1ns / 100ps

module load_store_machine_cycle_sequencer_tb;

    import lssq_pkg::*;

    // Selects and kinds that the package leaves unnamed
    localparam logic [2:0] SEL_UNUSED     = 3'd7;
    localparam logic [3:0] KIND_UNUSED_LO = 4'd11;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    // Slots of the pair file (BC, DE, HL, AF, IX, IY); SP lives apart
    localparam int SLOT_SP   = -1;
    localparam int SLOT_NONE = -2;

    localparam int PHASE_BEATS = 412;
    localparam int MAX_REPORTS = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    load_store_machine_cycle_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Directed row: one input beat, plus an expected result where it is obvious
    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  pair_sel;
        logic [2:0]  reg_sel;
        logic [7:0]  read_data;
        logic        typed;
        bus_kind_t   bus_kind;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        done_res;
    } dir_row_t;

    dir_row_t dir_table [23] = '{
        // unused kind right after reset completes at once
        '{KIND_UNUSED_HI, SEL_UNUSED, SEL_UNUSED, 8'hFF, 1'b1, BUS_NONE,  16'h0000, 8'h00, 1'b1},
        // st (HL),A from reset values
        '{KIND_ST_HL_R,   PAIR_BC,    REG_A,      8'h00, 1'b1, BUS_WRITE, 16'hFFFF, 8'hFF, 1'b0},
        '{KIND_ST_HL_R,   PAIR_BC,    REG_A,      8'h00, 1'b1, BUS_NONE,  16'hFFFF, 8'h00, 1'b1},
        // ld r,n into the unused register select
        '{KIND_LD_R_IMM,  PAIR_BC,    SEL_UNUSED, 8'h00, 1'b1, BUS_READ,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_R_IMM,  PAIR_BC,    SEL_UNUSED, 8'hAA, 1'b1, BUS_NONE,  16'h0000, 8'h00, 1'b1},
        // ld SP,nn
        '{KIND_LD_RR_IMM, PAIR_SP,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_RR_IMM, PAIR_SP,    REG_A,      8'h34, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_RR_IMM, PAIR_SP,    REG_A,      8'h12, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        // push of the unused pair, then a kind change past the last step
        '{KIND_PUSH,      SEL_UNUSED, REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_PUSH,      SEL_UNUSED, REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_PUSH,      SEL_UNUSED, REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_ST_HL_R,   PAIR_BC,    REG_B,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        // pop into SP: the final increment wins
        '{KIND_POP,       PAIR_SP,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_POP,       PAIR_SP,    REG_A,      8'h80, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_POP,       PAIR_SP,    REG_A,      8'hC3, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        // ld L,(HL)
        '{KIND_LD_R_HL,   PAIR_BC,    REG_L,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_R_HL,   PAIR_BC,    REG_L,      8'h55, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        // absolute-address kinds chained through one instruction
        '{KIND_ST_NN_RR,  PAIR_IX,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_RR_NN,  PAIR_IX,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_ST_NN_A,   PAIR_IX,    REG_A,      8'hFF, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_LD_A_NN,   PAIR_IX,    REG_A,      8'h5A, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        // st (IY),A
        '{KIND_ST_RR_A,   PAIR_IY,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0},
        '{KIND_ST_RR_A,   PAIR_IY,    REG_A,      8'h00, 1'b0, BUS_NONE,  16'h0000, 8'h00, 1'b0}
    };

    // Model state of the sequencer
    logic [2:0]  cpu_step;
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;
    logic [15:0] cpu_pairs [6];
    logic [7:0]  cpu_tmp;
    logic [15:0] cpu_addr;
    bus_kind_t   cpu_ck;

    result_t pending_cycles [$];
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    int      beats_sent = 0;
    int      cycles_checked = 0;
    int      instr_done = 0;
    int      fail_count = 0;

    function automatic int pair_slot(logic [2:0] sel);
        case (sel)
            PAIR_BC: return 0;
            PAIR_DE: return 1;
            PAIR_HL: return 2;
            PAIR_SP: return SLOT_SP;
            PAIR_AF: return 3;
            PAIR_IX: return 4;
            PAIR_IY: return 5;
            default: return SLOT_NONE;
        endcase
    endfunction

    function automatic logic [15:0] pair_read(logic [2:0] sel);
        int slot;
        slot = pair_slot(sel);
        if (slot == SLOT_SP)
            return cpu_sp;
        if (slot == SLOT_NONE)
            return 16'h0000;
        return cpu_pairs[slot];
    endfunction

    function automatic void pair_write_byte(logic [2:0] sel, bit hi, logic [7:0] v);
        int          slot;
        logic [15:0] cur;
        slot = pair_slot(sel);
        if (slot == SLOT_NONE)
            return;
        cur = (slot == SLOT_SP) ? cpu_sp : cpu_pairs[slot];
        if (hi)
            cur[15:8] = v;
        else
            cur[7:0] = v;
        if (slot == SLOT_SP)
            cpu_sp = cur;
        else
            cpu_pairs[slot] = cur;
    endfunction

    // 8-bit register as a half of a pair slot
    function automatic void reg_place(logic [2:0] sel, output int slot, output bit hi);
        case (sel)
            REG_A:   begin slot = 3; hi = 1'b1; end
            REG_B:   begin slot = 0; hi = 1'b1; end
            REG_C:   begin slot = 0; hi = 1'b0; end
            REG_D:   begin slot = 1; hi = 1'b1; end
            REG_E:   begin slot = 1; hi = 1'b0; end
            REG_H:   begin slot = 2; hi = 1'b1; end
            REG_L:   begin slot = 2; hi = 1'b0; end
            default: begin slot = SLOT_NONE; hi = 1'b0; end
        endcase
    endfunction

    function automatic logic [7:0] reg_read(logic [2:0] sel);
        int slot;
        bit hi;
        reg_place(sel, slot, hi);
        if (slot == SLOT_NONE)
            return 8'h00;
        return hi ? cpu_pairs[slot][15:8] : cpu_pairs[slot][7:0];
    endfunction

    function automatic void reg_write(logic [2:0] sel, logic [7:0] v);
        int slot;
        bit hi;
        reg_place(sel, slot, hi);
        if (slot == SLOT_NONE)
            return;
        if (hi)
            cpu_pairs[slot][15:8] = v;
        else
            cpu_pairs[slot][7:0] = v;
    endfunction

    function automatic void fetch_operand();
        cpu_addr = cpu_pc;
        cpu_pc   = cpu_pc + 16'd1;
    endfunction

    function automatic void sequencer_reset();
        cpu_step = 3'd1;
        cpu_pc   = 16'h0000;
        cpu_sp   = 16'hFFFF;
        foreach (cpu_pairs[i])
            cpu_pairs[i] = 16'hFFFF;
        cpu_tmp  = 8'h00;
        cpu_addr = 16'h0000;
        cpu_ck   = BUS_READ;
    endfunction

    // One machine cycle: updates the model state, returns the next bus cycle
    function automatic result_t advance_sequencer(item_t it);
        logic [2:0]  s;
        logic [7:0]  wd;
        logic [15:0] pv;
        bit          done;
        result_t     r;
        s    = cpu_step;
        wd   = 8'h00;
        done = 1'b0;
        case (it.kind)
            KIND_ST_NN_RR, KIND_LD_RR_NN, KIND_ST_NN_A, KIND_LD_A_NN:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck = BUS_READ;
                    fetch_operand();
                end
                else if (s == 3'd2)
                begin
                    cpu_tmp = it.read_data;
                    fetch_operand();
                end
                else if (s == 3'd3)
                begin
                    cpu_addr = {it.read_data, cpu_tmp};
                    if (it.kind == KIND_ST_NN_RR)
                    begin
                        cpu_ck = BUS_WRITE;
                        pv     = pair_read(it.pair_sel);
                        wd     = pv[7:0];
                    end
                    else if (it.kind == KIND_ST_NN_A)
                    begin
                        cpu_ck = BUS_WRITE;
                        wd     = reg_read(REG_A);
                    end
                end
                else if (s == 3'd4)
                begin
                    if (it.kind == KIND_ST_NN_RR)
                    begin
                        cpu_addr = cpu_addr + 16'd1;
                        pv       = pair_read(it.pair_sel);
                        wd       = pv[15:8];
                    end
                    else if (it.kind == KIND_LD_RR_NN)
                    begin
                        pair_write_byte(it.pair_sel, 1'b0, it.read_data);
                        cpu_addr = cpu_addr + 16'd1;
                    end
                    else if (it.kind == KIND_ST_NN_A)
                        done = 1'b1;
                    else
                    begin
                        reg_write(REG_A, it.read_data);
                        done = 1'b1;
                    end
                end
                else if (s == 3'd5 && it.kind == KIND_LD_RR_NN)
                begin
                    pair_write_byte(it.pair_sel, 1'b1, it.read_data);
                    done = 1'b1;
                end
                else
                    done = 1'b1;
            end
            KIND_LD_R_HL:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck   = BUS_READ;
                    cpu_addr = pair_read(PAIR_HL);
                end
                else
                begin
                    if (s == 3'd2)
                        reg_write(it.reg_sel, it.read_data);
                    done = 1'b1;
                end
            end
            KIND_ST_HL_R:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck   = BUS_WRITE;
                    cpu_addr = pair_read(PAIR_HL);
                    wd       = reg_read(it.reg_sel);
                end
                else
                    done = 1'b1;
            end
            KIND_LD_RR_IMM:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck = BUS_READ;
                    fetch_operand();
                end
                else if (s == 3'd2)
                begin
                    pair_write_byte(it.pair_sel, 1'b0, it.read_data);
                    fetch_operand();
                end
                else
                begin
                    if (s == 3'd3)
                        pair_write_byte(it.pair_sel, 1'b1, it.read_data);
                    done = 1'b1;
                end
            end
            KIND_LD_R_IMM:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck = BUS_READ;
                    fetch_operand();
                end
                else
                begin
                    if (s == 3'd2)
                        reg_write(it.reg_sel, it.read_data);
                    done = 1'b1;
                end
            end
            KIND_ST_RR_A:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck   = BUS_WRITE;
                    cpu_addr = pair_read(it.pair_sel);
                    wd       = reg_read(REG_A);
                end
                else
                    done = 1'b1;
            end
            KIND_PUSH:
            begin
                if (s == 3'd1)
                    cpu_ck = BUS_INTERNAL;
                else if (s == 3'd2 || s == 3'd3)
                begin
                    // SP select sees the value after this decrement
                    cpu_ck   = BUS_WRITE;
                    cpu_sp   = cpu_sp - 16'd1;
                    cpu_addr = cpu_sp;
                    pv       = pair_read(it.pair_sel);
                    wd       = (s == 3'd2) ? pv[15:8] : pv[7:0];
                end
                else
                    done = 1'b1;
            end
            KIND_POP:
            begin
                if (s == 3'd1)
                begin
                    cpu_ck   = BUS_READ;
                    cpu_addr = cpu_sp;
                end
                else if (s == 3'd2)
                begin
                    pair_write_byte(it.pair_sel, 1'b0, it.read_data);
                    cpu_addr = cpu_addr + 16'd1;
                end
                else
                begin
                    if (s == 3'd3)
                    begin
                        pair_write_byte(it.pair_sel, 1'b1, it.read_data);
                        cpu_addr = cpu_addr + 16'd1;
                        cpu_sp   = cpu_addr;
                    end
                    done = 1'b1;
                end
            end
            default:
                done = 1'b1;
        endcase

        cpu_step = done ? 3'd1 : s + 3'd1;

        r.bus_kind    = done ? BUS_NONE : cpu_ck;
        r.bus_address = cpu_addr;
        r.write_data  = (!done && cpu_ck == BUS_WRITE) ? wd : 8'h00;
        r.done_res    = done;
        return r;
    endfunction

    // Offer one beat from a falling edge, predict it once taken; returns at a falling edge
    task automatic send_beat(item_t it, bit typed, result_t typed_res);
        result_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = advance_sequencer(it);
        pending_cycles.push_back(typed ? typed_res : pred);
        beats_sent++;
        @(negedge clk);
    endtask

    // Receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.bus_kind    = bus_kind_t'(m_axis_tuser);
            got.bus_address = m_axis_tdata[15:0];
            got.write_data  = m_axis_tdata[23:16];
            got.done_res    = m_axis_tlast;
            if (pending_cycles.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat kind=%0d addr=%h wdata=%h last=%b",
                             $realtime, got.bus_kind, got.bus_address, got.write_data,
                             got.done_res);
            end
            else
            begin
                want = pending_cycles.pop_front();
                cycles_checked++;
                if (want.done_res)
                    instr_done++;
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: beat %0d exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 $realtime, cycles_checked, want.bus_kind, want.bus_address,
                                 want.write_data, want.done_res, got.bus_kind,
                                 got.bus_address, got.write_data, got.done_res);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        item_t   it;
        result_t typed_res;
        int      target;
        int      drain;
        sequencer_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        foreach (dir_table[i])
        begin
            it.kind                = dir_table[i].kind;
            it.pair_sel            = dir_table[i].pair_sel;
            it.reg_sel             = dir_table[i].reg_sel;
            it.read_data           = dir_table[i].read_data;
            typed_res.bus_kind     = dir_table[i].bus_kind;
            typed_res.bus_address  = dir_table[i].bus_address;
            typed_res.write_data   = dir_table[i].write_data;
            typed_res.done_res     = dir_table[i].done_res;
            send_beat(it, dir_table[i].typed, typed_res);
        end

        // random instructions under four idle/stall mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 16; snk_stall_pct = 16; end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                // mostly whole instructions; now and then a field flips mid-way
                if ($urandom_range(9) == 0)
                    it.kind = 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
                else
                    it.kind = 4'($urandom_range(KIND_POP));
                it.pair_sel = 3'($urandom_range(7));
                it.reg_sel  = 3'($urandom_range(7));
                do
                begin
                    it.read_data = 8'($urandom_range(255));
                    if ($urandom_range(24) == 0)
                    begin
                        case ($urandom_range(2))
                            0: it.kind = 4'($urandom_range(15));
                            1: it.pair_sel = 3'($urandom_range(7));
                            default: it.reg_sel = 3'($urandom_range(7));
                        endcase
                    end
                    send_beat(it, 1'b0, '0);
                end
                while (cpu_step != 3'd1);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep watching for anything stray
        drain = 0;
        while (pending_cycles.size() != 0)
            @(posedge clk);
        while (drain < 10)
        begin
            @(posedge clk);
            drain++;
        end

        $display("%0d beats driven, %0d bus cycles checked, %0d instructions completed",
                 beats_sent, cycles_checked, instr_done);
        $display("idle mixes: none, sender 70%%, receiver 70%%, both 16%%; %0d mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_cycles.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
